[rtl/mss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and fixed widths for the mesh shear sort block.
// ----------------------------------------------------------------------------
package mss_pkg;

	localparam int DATA_W = 32;	// element width
	localparam int SIDE_W = 4;	// side register width
	localparam int CNT_W  = 7;	// element counter width
	localparam int STG_W  = 3;	// stage counter width

	// command word from controller to datapath
	typedef struct packed {
		logic rd_en;	// read one memory entry
		logic wr_en;	// write one lane back to memory
		logic sort_en;	// one compare-exchange round over the lanes
		logic odd;	// round parity: pairs start at lane 1
		logic desc;	// descending line
		logic out_en;	// read feeds the result port
		logic last;	// final element of the matrix
	} mss_cmd_t;

endpackage

[rtl/mss_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_ctrl
// Sequencer: load counting, line read / sort / write-back per phase and
// stage, and row-major readout of the finished matrix.
// ----------------------------------------------------------------------------
module mss_ctrl #(
	parameter int MAX_SIDE = 8,
	localparam int IW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
	localparam int SW = $clog2(MAX_SIDE + 1),
	localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       cfg_we,
	input  logic [mss_pkg::SIDE_W-1:0] cfg_data,
	output logic                       busy,
	output mss_pkg::mss_cmd_t          cmd,
	output logic [AW-1:0]              addr,
	output logic [IW-1:0]              lane,
	output logic [AW-1:0]              ld_addr,
	output logic [SW-1:0]              side
);
	import mss_pkg::*;

	localparam int PW = IW + SW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DRAIN,
		S_SORT,
		S_WRITE,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [SIDE_W-1:0] side_q;
	logic [CNT_W-1:0]  load_cnt_q;
	logic [CNT_W-1:0]  out_q;
	logic [STG_W-1:0]  stage_q;
	logic              col_q;
	logic [IW-1:0]     line_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     round_q;
	mss_cmd_t          cmd_q;
	mss_cmd_t          cmd_d;
	logic [AW-1:0]     addr_q;
	logic [IW-1:0]     lane_q;

	logic [SW-1:0]     m_w;
	logic [CNT_W-1:0]  n_w;
	logic [STG_W-1:0]  total_w;
	logic [IW-1:0]     hi_w;
	logic [IW-1:0]     lo_w;
	logic [PW-1:0]     pos_w;
	logic              idx_end_w;
	logic              line_end_w;
	logic              round_end_w;

	// ceil(log2(n)): count the powers of two below n
	function automatic logic [STG_W-1:0] stage_total(input logic [CNT_W-1:0] n);
		logic [STG_W-1:0] t;
		logic [CNT_W:0]   p;
		t = '0;
		for (int k = 0; k < CNT_W; k++) begin
			p = (CNT_W + 1)'(1) << k;
			if (p < {1'b0, n})
				t = t + STG_W'(1);
		end
		return t;
	endfunction

	// effective side, clamped to 1..MAX_SIDE
	always_comb begin
		if (side_q == '0)
			m_w = SW'(1);
		else if (side_q > SIDE_W'(MAX_SIDE))
			m_w = SW'(MAX_SIDE);
		else
			m_w = SW'(side_q);
	end

	assign n_w     = CNT_W'(m_w) * CNT_W'(m_w);
	assign total_w = stage_total(n_w);

	// line element address: row phase r*m+k, column phase k*m+r
	always_comb begin
		if (col_q) begin
			hi_w = idx_q;
			lo_w = line_q;
		end else begin
			hi_w = line_q;
			lo_w = idx_q;
		end
		pos_w = PW'(hi_w) * PW'(m_w) + PW'(lo_w);
	end

	assign idx_end_w   = (SW'(idx_q) == m_w - SW'(1));
	assign line_end_w  = (SW'(line_q) == m_w - SW'(1));
	assign round_end_w = (SW'(round_q) == m_w - SW'(1));

	// command for the current state
	always_comb begin
		cmd_d = '0;
		unique case (state_q)
			S_READ: begin
				cmd_d.rd_en = 1'b1;
			end
			S_SORT: begin
				cmd_d.sort_en = 1'b1;
				cmd_d.odd     = round_q[0];
				cmd_d.desc    = ~col_q & line_q[0];
			end
			S_WRITE: begin
				cmd_d.wr_en = 1'b1;
			end
			S_OUT: begin
				cmd_d.rd_en  = 1'b1;
				cmd_d.out_en = 1'b1;
				cmd_d.last   = (out_q == n_w - CNT_W'(1));
			end
			default: ;
		endcase
	end

	// state, counters and registered command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			side_q     <= SIDE_W'(MAX_SIDE);
			load_cnt_q <= '0;
			out_q      <= '0;
			stage_q    <= '0;
			col_q      <= 1'b0;
			line_q     <= '0;
			idx_q      <= '0;
			round_q    <= '0;
			cmd_q      <= '0;
			addr_q     <= '0;
			lane_q     <= '0;
		end else begin
			cmd_q <= cmd_d;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						side_q     <= cfg_data;
						load_cnt_q <= '0;
					end else if (accept) begin
						if (load_cnt_q + CNT_W'(1) == n_w) begin
							load_cnt_q <= '0;
							stage_q    <= '0;
							col_q      <= 1'b0;
							line_q     <= '0;
							idx_q      <= '0;
							out_q      <= '0;
							state_q    <= (total_w == '0) ? S_OUT : S_READ;
						end else begin
							load_cnt_q <= load_cnt_q + CNT_W'(1);
						end
					end
				end
				// fetch one line into the lanes
				S_READ: begin
					addr_q <= AW'(pos_w);
					lane_q <= idx_q;
					if (idx_end_w) begin
						idx_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				// let the last read land in its lane
				S_DRAIN: begin
					round_q <= '0;
					state_q <= S_SORT;
				end
				// odd-even transposition, m rounds
				S_SORT: begin
					if (round_end_w)
						state_q <= S_WRITE;
					else
						round_q <= round_q + IW'(1);
				end
				// write the sorted line back, then next line / phase / stage
				S_WRITE: begin
					addr_q <= AW'(pos_w);
					lane_q <= idx_q;
					if (idx_end_w) begin
						idx_q <= '0;
						if (line_end_w) begin
							line_q <= '0;
							if (!col_q) begin
								col_q   <= 1'b1;
								state_q <= S_READ;
							end else begin
								col_q <= 1'b0;
								if (stage_q == total_w - STG_W'(1)) begin
									stage_q <= '0;
									out_q   <= '0;
									state_q <= S_OUT;
								end else begin
									stage_q <= stage_q + STG_W'(1);
									state_q <= S_READ;
								end
							end
						end else begin
							line_q  <= line_q + IW'(1);
							state_q <= S_READ;
						end
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				// row-major readout, one beat per cycle
				S_OUT: begin
					addr_q <= AW'(out_q);
					if (out_q == n_w - CNT_W'(1)) begin
						out_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						out_q <= out_q + CNT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign cmd     = cmd_q;
	assign addr    = addr_q;
	assign lane    = lane_q;
	assign ld_addr = AW'(load_cnt_q);
	assign side    = m_w;

endmodule

[rtl/mss_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_dp
// Matrix memory, line lanes with a compare-exchange row, and result register.
// ----------------------------------------------------------------------------
module mss_dp #(
	parameter int MAX_SIDE = 8,
	localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
	localparam int SW    = $clog2(MAX_SIDE + 1),
	localparam int AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1,
	localparam int DEPTH = MAX_SIDE * MAX_SIDE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic signed [mss_pkg::DATA_W-1:0] element_value,
	input  mss_pkg::mss_cmd_t                 cmd,
	input  logic [AW-1:0]                     addr,
	input  logic [IW-1:0]                     lane,
	input  logic [AW-1:0]                     ld_addr,
	input  logic [SW-1:0]                     side,
	output logic                              result_valid,
	output logic signed [mss_pkg::DATA_W-1:0] sorted_value,
	output logic                              last_of_run
);
	import mss_pkg::*;

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] lane_q [MAX_SIDE];
	logic signed [DATA_W-1:0] lane_nx [MAX_SIDE];
	logic signed [DATA_W-1:0] rdata_s1;
	logic [IW-1:0]            lane_s1;
	logic                     cap_s1;
	logic                     out_s1;
	logic                     last_s1;

	// matrix memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (accept)
			mem[ld_addr] <= element_value;
		else if (cmd.wr_en)
			mem[addr] <= lane_q[lane];
		if (cmd.rd_en)
			rdata_s1 <= mem[addr];
		lane_s1 <= lane;
	end

	// read tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_s1  <= 1'b0;
			out_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			cap_s1  <= cmd.rd_en & ~cmd.out_en;
			out_s1  <= cmd.rd_en & cmd.out_en;
			last_s1 <= cmd.rd_en & cmd.last;
		end
	end

	// one transposition round: disjoint neighbor pairs inside the line
	always_comb begin
		for (int i = 0; i < MAX_SIDE; i++)
			lane_nx[i] = lane_q[i];
		for (int i = 0; i < MAX_SIDE - 1; i++) begin
			if (((i % 2) == int'(cmd.odd)) && (SW'(i + 1) < side)) begin
				if (cmd.desc ? (lane_q[i] < lane_q[i + 1]) : (lane_q[i] > lane_q[i + 1])) begin
					lane_nx[i]     = lane_q[i + 1];
					lane_nx[i + 1] = lane_q[i];
				end
			end
		end
	end

	// lanes: load from memory or take a sort round
	always_ff @(posedge clk) begin
		if (cap_s1)
			lane_q[lane_s1] <= rdata_s1;
		else if (cmd.sort_en)
			lane_q <= lane_nx;
	end

	assign result_valid = out_s1;
	assign sorted_value = rdata_s1;
	assign last_of_run  = last_s1;

endmodule

[rtl/mesh_shear_sort.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_shear_sort
// Shear sort of an M-by-M signed matrix into snake order.
//
// channel   signals                          dir  handshake
// item      start, busy, element_value       in   taken when start & !busy
// config    cfg_valid, cfg_ready, cfg_data   in   taken when valid & ready
// result    result_valid, sorted_value,      out  one-cycle strobe, no stall
//           last_of_run
//
// Elements load at one per cycle while busy is low. After the M*M-th
// element the block runs S = ceil(log2(M*M)) stages of 2M line sorts; each
// line takes M memory reads, a drain state, M compare-exchange rounds and
// M write-backs. The matrix then streams out at one beat per cycle, each
// beat passing the command register and the memory read register. busy is
// high from the last element to the last readout issue. Reset clears
// control only; the matrix memory needs no clearing. The receiver cannot
// stall results.
// ----------------------------------------------------------------------------
module mesh_shear_sort #(
	parameter int MAX_SIDE = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [mss_pkg::DATA_W-1:0] element_value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mss_pkg::SIDE_W-1:0]        cfg_data,
	output logic                              result_valid,
	output logic signed [mss_pkg::DATA_W-1:0] sorted_value,
	output logic                              last_of_run
);
	import mss_pkg::*;

	localparam int IW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;

	logic          accept;
	logic          cfg_we;
	mss_cmd_t      cmd;
	logic [AW-1:0] addr;
	logic [IW-1:0] lane;
	logic [AW-1:0] ld_addr;
	logic [SW-1:0] side;

	// config held off while an element beat is offered
	assign accept    = start & ~busy;
	assign cfg_ready = ~busy & ~start;
	assign cfg_we    = cfg_valid & cfg_ready;

	mss_ctrl #(
		.MAX_SIDE(MAX_SIDE)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.busy    (busy),
		.cmd     (cmd),
		.addr    (addr),
		.lane    (lane),
		.ld_addr (ld_addr),
		.side    (side)
	);

	mss_dp #(
		.MAX_SIDE(MAX_SIDE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.element_value(element_value),
		.cmd          (cmd),
		.addr         (addr),
		.lane         (lane),
		.ld_addr      (ld_addr),
		.side         (side),
		.result_valid (result_valid),
		.sorted_value (sorted_value),
		.last_of_run  (last_of_run)
	);

endmodule

[tb/sv/tb_mesh_shear_sort.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh_shear_sort
// Self-checking bench for the mesh shear sort block.
//
// A short directed pass covers the value extremes, a zero side register,
// the single-element case and a side write that drops a partly loaded
// matrix. Random matrices of random side, some above the maximum, follow,
// with random gaps on the element port. Every matrix is also sorted by a
// local shear sort, and each output beat is compared against the oldest
// expected beat.
// ----------------------------------------------------------------------------
module tb_mesh_shear_sort;

	import mss_pkg::*;

	localparam int MAX_SIDE    = 8;
	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int ITEM_TARGET = 400;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYC  = 8;
	localparam int REPORT_MAX  = 10;

	localparam logic [DATA_W-1:0] ELEM_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] ELEM_NEG = 32'hFFFF_FFFF;

	// one expected output beat
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} sorted_beat_t;

	// directed stimulus rows
	typedef enum logic {ROW_SIDE, ROW_ELEM} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [DATA_W-1:0] data;
		logic              typed;	// expected beat given in the row
		logic [DATA_W-1:0] want;
		logic              want_last;
	} dir_row_t;

	localparam int N_DIRECTED = 25;
	localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
		// partial load under the reset side, then dropped by a side write
		'{ROW_ELEM, ELEM_MAX,      1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, ELEM_MIN,      1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, 32'h0,         1'b0, 32'h0,    1'b0},
		// single element: straight back, marked last
		'{ROW_SIDE, 32'h1,         1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, ELEM_MIN,      1'b1, ELEM_MIN, 1'b1},
		'{ROW_ELEM, ELEM_MAX,      1'b1, ELEM_MAX, 1'b1},
		'{ROW_ELEM, ELEM_NEG,      1'b1, ELEM_NEG, 1'b1},
		'{ROW_ELEM, 32'h0,         1'b1, 32'h0,    1'b1},
		// side zero acts as one
		'{ROW_SIDE, 32'h0,         1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b1},
		// 2x2 with extremes
		'{ROW_SIDE, 32'h2,         1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, 32'h5,         1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, ELEM_NEG,      1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, ELEM_MAX,      1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, ELEM_MIN,      1'b0, 32'h0,    1'b0},
		// 3x3 with duplicates and near-extremes
		'{ROW_SIDE, 32'h3,         1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, ELEM_MIN,      1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, ELEM_MAX,      1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, ELEM_NEG,      1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, ELEM_NEG,      1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, 32'h1,         1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, ELEM_MIN,      1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, 32'h0,         1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, 32'h7FFF_FFFE, 1'b0, 32'h0,    1'b0},
		'{ROW_ELEM, 32'h8000_0001, 1'b0, 32'h0,    1'b0}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [DATA_W-1:0] element_value;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [SIDE_W-1:0]        cfg_data;
	logic                     result_valid;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     last_of_run;

	// local copy of the block state
	logic [SIDE_W-1:0]        side_reg;
	logic signed [DATA_W-1:0] mat_image [STORE_DEPTH];
	int unsigned              fill;

	sorted_beat_t sorted_due [$];
	sorted_beat_t head_beat;
	int           fault_count;
	int           cycle_count;
	int           items_sent;

	mesh_shear_sort #(
		.MAX_SIDE(MAX_SIDE)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.element_value(element_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.sorted_value (sorted_value),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// side in use: zero acts as one, clamp at the maximum
	function automatic int unsigned side_in_use();
		int unsigned m;
		m = side_reg;
		if (m < 1) m = 1;
		if (m > MAX_SIDE) m = MAX_SIDE;
		return m;
	endfunction

	// bubble sort of one row or column of the local matrix
	function automatic void order_line(int unsigned m, int unsigned base,
			int unsigned stride, bit down);
		logic signed [DATA_W-1:0] t;
		int unsigned a, b;
		for (int unsigned sweep = 0; sweep < m; sweep++) begin
			for (int unsigned p = 1; p < m; p++) begin
				a = base + (p - 1) * stride;
				b = base + p * stride;
				if (down ? (mat_image[a] < mat_image[b]) : (mat_image[a] > mat_image[b])) begin
					t = mat_image[a];
					mat_image[a] = mat_image[b];
					mat_image[b] = t;
				end
			end
		end
	endfunction

	// take one element; on a full matrix run the shear sort and, if kept, queue the output
	function automatic void absorb_element(logic [DATA_W-1:0] v, bit keep);
		int unsigned m, n, stages;
		m = side_in_use();
		n = m * m;
		mat_image[fill] = v;
		fill++;
		if (fill < n) return;
		stages = 0;
		while ((1 << stages) < n) stages++;
		for (int unsigned s = 0; s < stages; s++) begin
			for (int unsigned r = 0; r < m; r++) order_line(m, r * m, 1, r[0]);
			for (int unsigned c = 0; c < m; c++) order_line(m, c, m, 1'b0);
		end
		if (keep) begin
			for (int unsigned k = 0; k < n; k++)
				sorted_due.push_back('{mat_image[k], k == n - 1});
		end
		fill = 0;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// styles: 0 full range, 1 extremes heavy, 2 narrow range with repeats
	function automatic logic [DATA_W-1:0] pick_value(int unsigned style);
		logic [DATA_W-1:0] v;
		v = $urandom();
		if (style == 1) begin
			case ($urandom_range(0, 6))
				0: v = ELEM_MIN;
				1: v = ELEM_MAX;
				2: v = ELEM_NEG;
				3: v = 32'h0;
				4: v = 32'h8000_0001;
				default: ;
			endcase
		end else if (style == 2) begin
			v = $urandom_range(0, 8);
			v = v - 4;
		end
		return v;
	endfunction

	// one element beat; start stays high until accepted
	task automatic drive_element(logic [DATA_W-1:0] v, int unsigned gap, bit keep);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start         <= 1'b1;
		element_value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		absorb_element(v, keep);
		items_sent++;
	endtask

	// drop start and wait until the block has nothing left to deliver
	task automatic settle_block();
		@(negedge clk);
		start <= 1'b0;
		while (sorted_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic program_side(logic [SIDE_W-1:0] v);
		settle_block();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		side_reg = v;
		fill     = 0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// output checker
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (sorted_due.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("unexpected beat: value %0d last %0b", sorted_value, last_of_run);
			end else begin
				head_beat = sorted_due.pop_front();
				if (sorted_value !== head_beat.value || last_of_run !== head_beat.last) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("mismatch: value exp %0d got %0d, last exp %0b got %0b",
							head_beat.value, sorted_value, head_beat.last, last_of_run);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned pick, side, m, n, mats, style, partial;
		bit calm;

		arst_n        = 1'b0;
		start         = 1'b0;
		element_value = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		side_reg      = SIDE_W'(MAX_SIDE);
		fill          = 0;
		fault_count   = 0;
		cycle_count   = 0;
		items_sent    = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].kind == ROW_SIDE) begin
				program_side(DIRECTED[i].data[SIDE_W-1:0]);
			end else begin
				drive_element(DIRECTED[i].data, 0, !DIRECTED[i].typed);
				if (DIRECTED[i].typed)
					sorted_due.push_back('{$signed(DIRECTED[i].want), DIRECTED[i].want_last});
			end
		end

		// random matrices, mostly small sides
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) side = 0;
			else if (pick < 10) side = $urandom_range(9, 15);
			else if (pick < 22) side = $urandom_range(5, 8);
			else side = $urandom_range(1, 4);
			program_side(side[SIDE_W-1:0]);
			m    = side_in_use();
			n    = m * m;
			mats = (n > 16) ? 1 : $urandom_range(1, 3);
			calm = ($urandom_range(0, 3) == 0);
			for (int unsigned j = 0; j < mats; j++) begin
				style = $urandom_range(0, 2);
				for (int unsigned k = 0; k < n; k++)
					drive_element(pick_value(style), calm ? 0 : pick_gap(), 1'b1);
			end
			// broken matrix, dropped by the next side write
			if (n > 1 && $urandom_range(0, 9) == 0) begin
				partial = $urandom_range(1, n - 1);
				for (int unsigned k = 0; k < partial; k++)
					drive_element(pick_value(0), calm ? 0 : pick_gap(), 1'b1);
			end
		end

		settle_block();
		repeat (16) @(posedge clk);
		if (fault_count == 0 && sorted_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[mesh_shear_sort.f]
rtl/mss_pkg.sv
rtl/mss_ctrl.sv
rtl/mss_dp.sv
rtl/mesh_shear_sort.sv
tb/sv/tb_mesh_shear_sort.sv
